// ----- rtl/core/saar_pkg.sv -----
// Shared constants and types of the sensor axis alignment rotation core.
`timescale 1ns / 1ps
package saar_pkg;

   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int SAMPLE_WIDTH_DEF   = 16;

   // Angle registers and the configuration port.
   localparam int ANG_WIDTH       = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROLL  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PITCH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_YAW   = 2'd2;

   // A sine argument is an angle plus a quarter turn, so one bit wider.
   localparam int SIN_ANG_WIDTH = ANG_WIDTH + 1;
   localparam int QUARTER_TURN  = 900;

   // pi / 1800 in Q30.
   localparam logic [30:0] RAD_PER_DECIDEG_Q30 = 31'd1874033;

   typedef struct packed {
      logic busy;
      logic bypass;
   } saar_bld_stat_type;

endpackage

// ----- rtl/core/saar_if.sv -----
// Valid/ready stream interfaces for the sample and result channels.
`timescale 1ns / 1ps
interface saar_req_if #(parameter int SW = saar_pkg::SAMPLE_WIDTH_DEF);
   logic                 valid;
   logic                 ready;
   logic signed [SW-1:0] axis_x_in;
   logic signed [SW-1:0] axis_y_in;
   logic signed [SW-1:0] axis_z_in;

   modport source (output valid, output axis_x_in, output axis_y_in, output axis_z_in,
                   input ready);
   modport sink (input valid, input axis_x_in, input axis_y_in, input axis_z_in,
                 output ready);
endinterface

interface saar_rsp_if #(parameter int SW = saar_pkg::SAMPLE_WIDTH_DEF);
   logic                 valid;
   logic                 ready;
   logic signed [SW-1:0] axis_x_out;
   logic signed [SW-1:0] axis_y_out;
   logic signed [SW-1:0] axis_z_out;

   modport source (output valid, output axis_x_out, output axis_y_out, output axis_z_out,
                   input ready);
   modport sink (input valid, input axis_x_out, input axis_y_out, input axis_z_out,
                 output ready);
endinterface

// ----- rtl/core/saar_sin_unit.sv -----
// Iterative fixed-point sine of an angle in tenths of a degree (Taylor series, reciprocal division).
`timescale 1ns / 1ps
module saar_sin_unit #(
   parameter int COEF_FRAC_BITS = saar_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic signed [saar_pkg::SIN_ANG_WIDTH-1:0] angle,
   output logic                                      done,
   output logic signed [COEF_FRAC_BITS+1:0]          value
);
   import saar_pkg::*;

   localparam int CW    = COEF_FRAC_BITS + 2;
   localparam int SHIFT = 30 - COEF_FRAC_BITS;
   localparam logic [31:0] RND = 32'((64'd1 << SHIFT) >> 1);
   localparam logic [14:0] TURN    = 15'd3600;
   localparam logic [14:0] HALF_T  = 15'd1800;
   localparam logic [14:0] THREE_Q = 15'd2700;
   localparam logic [14:0] QUART   = 15'(QUARTER_TURN);
   localparam logic signed [16:0] ANG_OFFSET = 17'sd21600;
   localparam logic signed [33:0] SUM_MAX = 34'sd1073741824;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_X    = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_PROD = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_ACC  = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [14:0]           a_ff;
   logic [9:0]            r_ff;
   logic                  neg_ff;
   logic [30:0]           x_ff;
   logic [31:0]           x2_ff;
   logic [30:0]           term_ff;
   logic signed [33:0]    sum_ff;
   logic [2:0]            k_ff;
   logic [31:0]           nq_ff;
   logic [52:0]           lo_ff;
   logic                  ph_ff;
   logic [30:0]           quo_ff;
   logic                  done_ff;
   logic signed [CW-1:0]  value_ff;

   logic signed [16:0]    a_sum;
   logic [14:0]           r_fold;
   logic [30:0]           x_prod;
   logic [61:0]           sq;
   logic [61:0]           pr;
   logic [36:0]           mrec;
   logic [15:0]           mul_op;
   logic [52:0]           mp;
   logic [68:0]           qsum;
   logic signed [33:0]    q_ext;
   logic [30:0]           v_clamp;
   logic [31:0]           v_rnd;
   logic signed [CW-1:0]  mag;

   // The divisor (2k)(2k+1) of the k-th Taylor term is a power of two times an odd factor.
   // The dividend is shifted down by the power of two, then multiplied by ceil(2^38 / factor);
   // this is exact for dividends below 2^32, which the term products never reach.
   function automatic logic [36:0] term_recip(input logic [2:0] k);
      logic [36:0] m;
      unique case (k)
         3'd1:    m = 37'd91625968982;
         3'd2:    m = 37'd54975581389;
         3'd3:    m = 37'd13089424141;
         3'd4:    m = 37'd30541989661;
         3'd5:    m = 37'd4997780127;
         3'd6:    m = 37'd7048151461;
         default: m = 37'd91625968982;
      endcase
      return m;
   endfunction

   function automatic logic [1:0] term_shift(input logic [2:0] k);
      logic [1:0] s;
      unique case (k)
         3'd1:    s = 2'd1;
         3'd2:    s = 2'd2;
         3'd3:    s = 2'd1;
         3'd4:    s = 2'd3;
         3'd5:    s = 2'd1;
         3'd6:    s = 2'd2;
         default: s = 2'd1;
      endcase
      return s;
   endfunction

   always_comb begin
      a_sum  = 17'(angle) + ANG_OFFSET;
      if (a_ff <= QUART) begin
         r_fold = a_ff;
      end else if (a_ff <= HALF_T) begin
         r_fold = HALF_T - a_ff;
      end else if (a_ff <= THREE_Q) begin
         r_fold = a_ff - HALF_T;
      end else begin
         r_fold = TURN - a_ff;
      end
      x_prod = 31'(r_ff) * RAD_PER_DECIDEG_Q30;
      sq     = 62'(x_ff) * 62'(x_ff);
      pr     = 62'(term_ff) * 62'(x2_ff);
      mrec   = term_recip(k_ff);
      // The reciprocal product is built from two 16-bit halves of the dividend.
      mul_op = ph_ff ? nq_ff[31:16] : nq_ff[15:0];
      mp     = 53'(mul_op) * 53'(mrec);
      qsum   = {mp, 16'b0} + 69'(lo_ff);
      q_ext  = {3'b000, quo_ff};
      if (sum_ff < 0) begin
         v_clamp = '0;
      end else if (sum_ff > SUM_MAX) begin
         v_clamp = SUM_MAX[30:0];
      end else begin
         v_clamp = sum_ff[30:0];
      end
      v_rnd = ({1'b0, v_clamp} + RND) >> SHIFT;
      mag   = v_rnd[CW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_RED;
         ST_RED:  if (a_ff < TURN) state_in = ST_X;
         ST_X:    state_in = ST_SQR;
         ST_SQR:  state_in = ST_PROD;
         ST_PROD: state_in = ST_DIV;
         ST_DIV:  if (ph_ff) state_in = ST_ACC;
         ST_ACC:  state_in = (k_ff == 3'd6) ? ST_FIN : ST_PROD;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == ST_FIN);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            a_ff <= a_sum[14:0];
         end
         ST_RED: begin
            if (a_ff >= TURN) begin
               a_ff <= a_ff - TURN;
            end else begin
               r_ff   <= r_fold[9:0];
               neg_ff <= (a_ff > HALF_T);
            end
         end
         ST_X: begin
            x_ff <= x_prod;
         end
         ST_SQR: begin
            x2_ff   <= sq[61:30];
            term_ff <= x_ff;
            sum_ff  <= 34'(x_ff);
            k_ff    <= 3'd1;
         end
         ST_PROD: begin
            nq_ff <= pr[61:30] >> term_shift(k_ff);
            ph_ff <= 1'b0;
         end
         ST_DIV: begin
            if (!ph_ff) begin
               lo_ff <= mp;
               ph_ff <= 1'b1;
            end else begin
               quo_ff <= qsum[68:38];
            end
         end
         ST_ACC: begin
            term_ff <= quo_ff;
            sum_ff  <= k_ff[0] ? (sum_ff - q_ext) : (sum_ff + q_ext);
            k_ff    <= k_ff + 3'd1;
         end
         ST_FIN: begin
            value_ff <= neg_ff ? -mag : mag;
         end
         default: begin
            a_ff <= a_ff;
         end
      endcase
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

// ----- rtl/core/saar_builder.sv -----
// Rotation matrix builder: six sines, then thirteen rounded products on one shared multiplier.
`timescale 1ns / 1ps
module saar_builder #(
   parameter int COEF_FRAC_BITS = saar_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [saar_pkg::ANG_WIDTH-1:0] roll,
   input  logic signed [saar_pkg::ANG_WIDTH-1:0] pitch,
   input  logic signed [saar_pkg::ANG_WIDTH-1:0] yaw,
   output saar_pkg::saar_bld_stat_type           status,
   output logic signed [COEF_FRAC_BITS+1:0]      coef [9]
);
   import saar_pkg::*;

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = 2 * CW;
   localparam logic signed [CW-1:0] ONE  = CW'(64'd1 << COEF_FRAC_BITS);
   localparam logic [PW-1:0]        HALF = PW'(64'd1 << (COEF_FRAC_BITS - 1));
   localparam logic signed [SIN_ANG_WIDTH-1:0] QUARTER = SIN_ANG_WIDTH'(QUARTER_TURN);
   localparam logic [3:0] LAST_STEP = 4'd12;
   localparam logic [3:0] FIRST_COEF_STEP = 4'd4;

   localparam logic [2:0] B_IDLE     = 3'd0;
   localparam logic [2:0] B_SIN_GO   = 3'd1;
   localparam logic [2:0] B_SIN_WAIT = 3'd2;
   localparam logic [2:0] B_MUL      = 3'd3;
   localparam logic [2:0] B_ACC      = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  busy_ff;
   logic                  pend_ff;
   logic                  bypass_ff;
   logic [2:0]            sidx_ff;
   logic [3:0]            step_ff;
   logic signed [CW-1:0]  sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;
   logic signed [CW-1:0]  czcx_ff, szcx_ff, czsx_ff, szsx_ff;
   logic signed [PW-1:0]  prod_ff;
   logic                  neg_ff;
   logic signed [CW-1:0]  addend_ff;
   logic signed [CW-1:0]  coef_ff [9];

   logic                          go;
   logic                          sin_done;
   logic signed [CW-1:0]          sin_value;
   logic signed [SIN_ANG_WIDTH-1:0] sin_angle;
   logic signed [ANG_WIDTH-1:0]   base_angle;
   logic signed [CW-1:0]          opa, opb, addend;
   logic                          negate;
   logic [PW-1:0]                 mag;
   logic [PW-1:0]                 rnd_sum;
   logic signed [CW-1:0]          rounded;
   logic signed [CW-1:0]          result;
   logic [3:0]                    coef_idx;

   saar_sin_unit #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sin (
      .clock (clock),
      .reset (reset),
      .start (state_ff == B_SIN_GO),
      .angle (sin_angle),
      .done  (sin_done),
      .value (sin_value)
   );

   // A write that lands during a build is remembered and starts another build afterwards.
   assign go = start || pend_ff;

   // Even slots take the sine of an angle, odd slots the cosine.
   always_comb begin
      unique case (sidx_ff[2:1])
         2'd0:    base_angle = roll;
         2'd1:    base_angle = pitch;
         default: base_angle = yaw;
      endcase
      sin_angle = SIN_ANG_WIDTH'(base_angle) + (sidx_ff[0] ? QUARTER : '0);
   end

   // Operands of each product step; the result is addend plus or minus the rounded product.
   always_comb begin
      opa    = sx_ff;
      opb    = ONE;
      addend = '0;
      negate = 1'b0;
      unique case (step_ff)
         4'd0:  begin opa = cz_ff;   opb = cx_ff; end
         4'd1:  begin opa = sz_ff;   opb = cx_ff; end
         4'd2:  begin opa = sx_ff;   opb = cz_ff; end
         4'd3:  begin opa = sx_ff;   opb = sz_ff; end
         4'd4:  begin opa = cz_ff;   opb = cy_ff; end
         4'd5:  begin opa = cy_ff;   opb = sz_ff; negate = 1'b1; end
         4'd6:  begin opa = sy_ff;   opb = ONE; end
         4'd7:  begin opa = czsx_ff; opb = sy_ff; addend = szcx_ff; end
         4'd8:  begin opa = szsx_ff; opb = sy_ff; addend = czcx_ff; negate = 1'b1; end
         4'd9:  begin opa = sx_ff;   opb = cy_ff; negate = 1'b1; end
         4'd10: begin opa = czcx_ff; opb = sy_ff; addend = szsx_ff; negate = 1'b1; end
         4'd11: begin opa = szcx_ff; opb = sy_ff; addend = czsx_ff; end
         4'd12: begin opa = cy_ff;   opb = cx_ff; end
         default: begin opa = sx_ff; opb = ONE; end
      endcase
   end

   // Round half away from zero on the magnitude, then restore the sign.
   always_comb begin
      mag      = (prod_ff < 0) ? PW'(-prod_ff) : PW'(prod_ff);
      rnd_sum  = mag + HALF;
      rounded  = CW'(rnd_sum >> COEF_FRAC_BITS);
      result   = ((prod_ff < 0) ^ neg_ff) ? (addend_ff - rounded) : (addend_ff + rounded);
      coef_idx = step_ff - FIRST_COEF_STEP;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:     if (go) state_in = B_SIN_GO;
         B_SIN_GO:   state_in = B_SIN_WAIT;
         B_SIN_WAIT: if (sin_done) state_in = (sidx_ff == 3'd5) ? B_MUL : B_SIN_GO;
         B_MUL:      state_in = B_ACC;
         B_ACC:      state_in = (step_ff == LAST_STEP) ? B_IDLE : B_MUL;
         default:    state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         busy_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         bypass_ff <= 1'b1;
         for (int i = 0; i < 9; i++) begin
            coef_ff[i] <= ((i % 4) == 0) ? ONE : '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE) begin
            pend_ff <= 1'b0;
         end else if (start) begin
            pend_ff <= 1'b1;
         end
         if (state_ff == B_IDLE && go) begin
            busy_ff   <= 1'b1;
            bypass_ff <= (roll == '0) && (pitch == '0) && (yaw == '0);
         end
         if (state_ff == B_ACC) begin
            if (step_ff >= FIRST_COEF_STEP) begin
               coef_ff[coef_idx] <= result;
            end
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            sidx_ff <= '0;
            step_ff <= '0;
         end
         B_SIN_WAIT: begin
            if (sin_done) begin
               sidx_ff <= sidx_ff + 3'd1;
               unique case (sidx_ff)
                  3'd0:    sx_ff <= sin_value;
                  3'd1:    cx_ff <= sin_value;
                  3'd2:    sy_ff <= sin_value;
                  3'd3:    cy_ff <= sin_value;
                  3'd4:    sz_ff <= sin_value;
                  default: cz_ff <= sin_value;
               endcase
            end
         end
         B_MUL: begin
            prod_ff   <= opa * opb;
            neg_ff    <= negate;
            addend_ff <= addend;
         end
         B_ACC: begin
            step_ff <= step_ff + 4'd1;
            unique case (step_ff)
               4'd0:    czcx_ff <= result;
               4'd1:    szcx_ff <= result;
               4'd2:    czsx_ff <= result;
               4'd3:    szsx_ff <= result;
               default: czcx_ff <= czcx_ff;
            endcase
         end
         default: begin
            sidx_ff <= sidx_ff;
         end
      endcase
   end

   assign status.busy   = busy_ff || pend_ff;
   assign status.bypass = bypass_ff;
   assign coef          = coef_ff;

endmodule

// ----- rtl/core/sensor_axis_alignment_rotation_core.sv -----
// Top level of the sensor axis alignment rotation core.
`timescale 1ns / 1ps
// Rotates each three-axis sample by the mounting alignment held in the roll, pitch and yaw
// registers (tenths of a degree). Samples flow through a three-stage pipeline (products,
// sums, truncation and saturation), and a new sample can enter while earlier ones are still
// in the stages; a stalled result channel backs up the stages without loss.
// A write to an angle register rebuilds the matrix: the core then takes no sample while it
// computes six sines (each by angle reduction and six Taylor terms, every division done by
// a two-step reciprocal multiply) and then thirteen products on the shared matrix
// multiplier. A write that arrives during a rebuild starts a further rebuild once the
// current one ends.
// With all three angles zero, samples pass through unchanged.
module sensor_axis_alignment_rotation_core #(
   parameter int COEF_FRAC_BITS = saar_pkg::COEF_FRAC_BITS_DEF,
   parameter int SAMPLE_WIDTH   = saar_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   saar_req_if.sink                                req_chan,
   saar_rsp_if.source                              rsp_chan,
   input  logic                                    csr_we,
   input  logic [saar_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [saar_pkg::ANG_WIDTH-1:0]          csr_wdata
);
   import saar_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = CW + SW;
   localparam int AW = PW + 2;
   localparam int QW = AW - COEF_FRAC_BITS;
   localparam logic signed [AW-1:0] BIAS =
      {{(AW - COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
   localparam logic signed [QW-1:0] SAT_HI = {{(QW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [QW-1:0] SAT_LO = {{(QW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

   logic signed [ANG_WIDTH-1:0] roll_ff, pitch_ff, yaw_ff;
   logic                        start_ff, start_in;
   saar_bld_stat_type           bld_stat;
   logic signed [CW-1:0]        coef [9];

   logic                  v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0]  p1_ff [3][3];
   logic signed [SW-1:0]  s1_ff [3];
   logic signed [AW-1:0]  acc2_ff [3];
   logic signed [SW-1:0]  s2_ff [3];
   logic signed [SW-1:0]  out3_ff [3];

   logic                  adv1, adv2, adv3;
   logic                  take;
   logic signed [SW-1:0]  samp [3];
   logic signed [AW-1:0]  adj [3];
   logic signed [QW-1:0]  quo [3];
   logic signed [SW-1:0]  res [3];

   always_comb begin
      start_in = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            REG_ROLL, REG_PITCH, REG_YAW: start_in = 1'b1;
            default:                      start_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff  <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_ROLL:  roll_ff  <= csr_wdata;
               REG_PITCH: pitch_ff <= csr_wdata;
               REG_YAW:   yaw_ff   <= csr_wdata;
               default:   roll_ff  <= roll_ff;
            endcase
         end
      end
   end

   saar_builder #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_builder (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .roll   (roll_ff),
      .pitch  (pitch_ff),
      .yaw    (yaw_ff),
      .status (bld_stat),
      .coef   (coef)
   );

   // Each stage loads when it is empty or its contents move on in the same cycle.
   assign adv3 = !v3_ff || rsp_chan.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_chan.ready = adv1 && !start_ff && !bld_stat.busy;
   assign take = req_chan.valid && req_chan.ready;

   assign samp[0] = req_chan.axis_x_in;
   assign samp[1] = req_chan.axis_y_in;
   assign samp[2] = req_chan.axis_z_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         adj[j] = acc2_ff[j] + (acc2_ff[j][AW-1] ? BIAS : '0);
         quo[j] = QW'(adj[j] >>> COEF_FRAC_BITS);
         if (bld_stat.bypass) begin
            res[j] = s2_ff[j];
         end else if (quo[j] > SAT_HI) begin
            res[j] = SW'(SAT_HI);
         end else if (quo[j] < SAT_LO) begin
            res[j] = SW'(SAT_LO);
         end else begin
            res[j] = SW'(quo[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= take;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int j = 0; j < 3; j++) begin
            s1_ff[j] <= samp[j];
            for (int k = 0; k < 3; k++) begin
               p1_ff[j][k] <= coef[k * 3 + j] * samp[k];
            end
         end
      end
      if (adv2) begin
         for (int j = 0; j < 3; j++) begin
            s2_ff[j]   <= s1_ff[j];
            acc2_ff[j] <= AW'(p1_ff[j][0]) + AW'(p1_ff[j][1]) + AW'(p1_ff[j][2]);
         end
      end
      if (adv3) begin
         for (int j = 0; j < 3; j++) begin
            out3_ff[j] <= res[j];
         end
      end
   end

   assign rsp_chan.valid      = v3_ff;
   assign rsp_chan.axis_x_out = out3_ff[0];
   assign rsp_chan.axis_y_out = out3_ff[1];
   assign rsp_chan.axis_z_out = out3_ff[2];

endmodule

// ----- rtl/core/saar_checker.sv -----
// Port-level checks of the rotation core and their attachment to the top level.
`timescale 1ns / 1ps
module saar_checker #(
   parameter int SW = saar_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [SW-1:0]                        rsp_x,
   input logic [SW-1:0]                        rsp_y,
   input logic [SW-1:0]                        rsp_z,
   input logic                                 csr_we,
   input logic [saar_pkg::CSR_INDEX_WIDTH-1:0] csr_index
);
   import saar_pkg::*;

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z))
      else $error("stalled result changed");

   // An angle write must hold off samples while the matrix is rebuilt.
   assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_ROLL || csr_index == REG_PITCH || csr_index == REG_YAW)
      |=> !req_ready)
      else $error("sample accepted during matrix rebuild");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

endmodule

bind sensor_axis_alignment_rotation_core saar_checker #(.SW(SAMPLE_WIDTH)) u_saar_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_x     (rsp_chan.axis_x_out),
   .rsp_y     (rsp_chan.axis_y_out),
   .rsp_z     (rsp_chan.axis_z_out),
   .csr_we    (csr_we),
   .csr_index (csr_index)
);
